// File: hdl/transposed_fir_stencil_top_defines.svh
// Assertion macros used by the filter's top-level RTL.
`ifndef TRANSPOSED_FIR_STENCIL_TOP_DEFINES_SVH
`define TRANSPOSED_FIR_STENCIL_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define TFS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define TFS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/tfs_pkg.sv
package tfs_pkg;

   // Width of the partial sums and of the filtered result (Q11.31).
   localparam int SUM_BITS = 42;
   // Width of the coefficient position field.
   localparam int INDEX_BITS = 8;

   typedef enum logic [0:0] {
      OP_FILTER = 1'b0,
      OP_LOAD   = 1'b1
   } tfs_op_type;

   // Control broadcast from the top level to every tap cell.
   typedef struct packed {
      logic                  load;
      logic [INDEX_BITS-1:0] tap_index;
      logic                  shift;
   } tfs_ctl_type;

endpackage

// File: hdl/tfs_if.sv
interface tfs_req_if #(
   parameter int SAMPLE_BITS = 16,
   parameter int COEF_BITS   = 18
);
   logic                                 valid;
   logic                                 ready;
   tfs_pkg::tfs_op_type                  operation;
   logic [tfs_pkg::INDEX_BITS-1:0]       tap_index;
   logic signed [SAMPLE_BITS-1:0]        sample;
   logic signed [COEF_BITS-1:0]          coefficient;

   modport source (output valid, operation, tap_index, sample, coefficient, input ready);
   modport sink (input valid, operation, tap_index, sample, coefficient, output ready);
endinterface

interface tfs_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [tfs_pkg::SUM_BITS-1:0]  filtered_value;

   modport source (output valid, filtered_value, input ready);
   modport sink (input valid, filtered_value, output ready);
endinterface

// File: hdl/tfs_cell.sv
// One tap of the transposed chain: holds c[IDX] and, for IDX > 0, the partial
// sum that it hands to its left neighbor on every shift.
module tfs_cell #(
   parameter int IDX         = 0,
   parameter int SAMPLE_BITS = 16,
   parameter int COEF_BITS   = 18
) (
   input  logic                                clock,
   input  logic                                reset,
   input  tfs_pkg::tfs_ctl_type                ctl,
   input  logic signed [COEF_BITS-1:0]         coefficient,
   input  logic signed [SAMPLE_BITS-1:0]       x,
   input  logic        [tfs_pkg::SUM_BITS-1:0] sum_in,
   output logic        [tfs_pkg::SUM_BITS-1:0] sum_out
);

   localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;
   localparam int SB        = tfs_pkg::SUM_BITS;

   logic [COEF_BITS-1:0]      coef_ff;
   logic [COEF_BITS-1:0]      coef_in;
   logic [PROD_BITS-1:0]      prod;
   logic [PROD_BITS+SB-1:0]   prod_ext;
   logic [SB-1:0]             mac;

   assign coef_in = (ctl.load && (ctl.tap_index == tfs_pkg::INDEX_BITS'(IDX)))
                    ? coefficient : coef_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else begin
         coef_ff <= coef_in;
      end
   end

   // Exact product, then sign-extended and wrapped to the sum width.
   assign prod = $signed({{COEF_BITS{x[SAMPLE_BITS-1]}}, x})
               * $signed({{SAMPLE_BITS{coef_ff[COEF_BITS-1]}}, coef_ff});
   assign prod_ext = {{SB{prod[PROD_BITS-1]}}, prod};
   assign mac = sum_in + prod_ext[SB-1:0];

   generate
      if (IDX == 0) begin : g_head
         assign sum_out = mac;
      end else begin : g_body
         logic [SB-1:0] acc_ff;
         logic [SB-1:0] acc_in;

         assign acc_in = ctl.shift ? mac : acc_ff;

         always_ff @(posedge clock) begin
            if (reset) begin
               acc_ff <= '0;
            end else begin
               acc_ff <= acc_in;
            end
         end

         assign sum_out = acc_ff;
      end
   endgenerate

endmodule

// File: hdl/transposed_fir_stencil_top.sv
// Transposed-form FIR filter: y[n] = sum over j of c[j] * x[n-j], with
// samples before the first one after reset counting as zero.
// The request channel carries two kinds of transaction. A load writes one
// Q2.16 coefficient at tap_index (an index at or beyond TAPS is dropped) and
// returns nothing. A filter transaction carries one Q1.15 sample and returns
// exactly one Q11.31 filtered_value on the response channel, in order.
// An accepted sample is registered in the input stage, multiplied into all
// TAPS cells when the chain shifts, and its finished sum is registered in
// the response register. Throughput is one transaction per cycle when the
// receiver does not stall: every cell does one multiply-add per shift, and
// the chain of partial sums moves one place per sample.
// A load that follows a sample affects only later samples.
// When the receiver stalls, the response register holds its value, one more
// sample waits in the input stage, and then req_bus.ready falls; the chain
// shifts only when a finished sum can move into the response register.
// Reset (synchronous, active high) clears all coefficients and partial sums
// to zero and empties both stages.
`include "transposed_fir_stencil_top_defines.svh"

module transposed_fir_stencil_top #(
   parameter int TAPS        = 161,
   parameter int SAMPLE_BITS = 16,
   parameter int COEF_BITS   = 18
) (
   input  logic         clock,
   input  logic         reset,
   tfs_req_if.sink      req_bus,
   tfs_rsp_if.source    rsp_bus
);

   localparam int SB = tfs_pkg::SUM_BITS;

   // Input stage: the sample waiting to be pushed through the cells.
   logic                          s1_valid_ff;
   logic                          s1_valid_in;
   logic [SAMPLE_BITS-1:0]        x_ff;
   logic [SAMPLE_BITS-1:0]        x_in;

   // Response register.
   logic                          out_valid_ff;
   logic                          out_valid_in;
   logic [SB-1:0]                 out_data_ff;
   logic [SB-1:0]                 out_data_in;

   logic                          advance;
   logic                          req_take;
   logic                          take_filter;
   tfs_pkg::tfs_ctl_type          ctl;

   // chain[j] is what cell j hands to its left; the right end feeds zeros.
   logic [SB-1:0]                 chain [TAPS+1];

   // The chain may shift whenever the response register is free or is
   // being emptied in this cycle.
   assign advance     = !out_valid_ff || rsp_bus.ready;
   assign req_bus.ready = !s1_valid_ff || advance;
   assign req_take    = req_bus.valid && req_bus.ready;
   assign take_filter = req_take && (req_bus.operation == tfs_pkg::OP_FILTER);

   assign s1_valid_in = req_bus.ready ? take_filter : s1_valid_ff;
   assign x_in        = take_filter ? req_bus.sample : x_ff;

   assign ctl.load      = req_take && (req_bus.operation == tfs_pkg::OP_LOAD);
   assign ctl.tap_index = req_bus.tap_index;
   assign ctl.shift     = s1_valid_ff && advance;

   assign out_valid_in = advance ? ctl.shift : out_valid_ff;
   assign out_data_in  = ctl.shift ? chain[0] : out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      out_data_ff <= out_data_in;
   end

   assign chain[TAPS] = '0;

   // The row of tap cells. Cell 0 produces the finished sum; every other
   // cell keeps the partial sum for an output still to come.
   generate
      for (genvar j = 0; j < TAPS; j++) begin : g_tap
         tfs_cell #(
            .IDX         (j),
            .SAMPLE_BITS (SAMPLE_BITS),
            .COEF_BITS   (COEF_BITS)
         ) u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctl         (ctl),
            .coefficient (req_bus.coefficient),
            .x           (x_ff),
            .sum_in      (chain[j+1]),
            .sum_out     (chain[j])
         );
      end
   endgenerate

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.filtered_value = out_data_ff;

   // A waiting sample must not be lost or altered while the chain is blocked.
   `TFS_ASSERT_NEXT(a_s1_hold, clock, reset, s1_valid_ff && !advance, s1_valid_ff && $stable(x_ff), "input stage changed while stalled")
   // An accepted sample always lands in the input stage.
   `TFS_ASSERT_NEXT(a_s1_fill, clock, reset, take_filter, s1_valid_ff, "accepted sample not staged")
   // Every response comes from a sample that was shifted through the cells.
   `TFS_ASSERT_NOW(a_out_src, clock, reset, $rose(out_valid_ff), $past(ctl.shift), "response without a shifted sample")
   // A load transaction never creates a response.
   `TFS_ASSERT_NEXT(a_load_quiet, clock, reset, ctl.load && !s1_valid_ff && !out_valid_ff, !out_valid_ff, "load produced a response")

endmodule
